@@ hw/rtl/dmacr_pkg.sv @@
`timescale 1ns / 1ps

package dmacr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_CAPTURE    = 3'd1;
  localparam logic [2:0] REG_RD_LAT     = 3'd2;
  localparam logic [2:0] REG_WR_LAT     = 3'd3;
  localparam logic [2:0] REG_XFER_SIZE  = 3'd4;
  localparam logic [2:0] REG_RING_BASE  = 3'd5;
  localparam logic [2:0] REG_RING_LOG2  = 3'd6;

  // Element size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 168;

  // Channel configuration
  typedef struct packed {
    logic        channel_enabled;
    logic        capture_mode;
    logic [7:0]  read_latency;
    logic [7:0]  write_latency;
    logic [1:0]  transfer_size;
    logic [31:0] ring_start;
    logic [4:0]  ring_order;
  } cfg_t;

  // Channel state carried from tick to tick
  typedef struct packed {
    logic [7:0]  read_countdown;
    logic [7:0]  write_countdown;
    logic [31:0] pending_address;
    logic [31:0] pending_value;
    logic [7:0]  capture_countdown;
    logic [31:0] capture_value;
    logic [31:0] ring_pointer;
  } state_t;

  // One tick of input, last field in the lowest bits
  typedef struct packed {
    logic [31:0] mem_data_in;
    logic        dst_full;
    logic [31:0] src_word;
    logic        src_has_data;
  } tick_in_t;

  // One tick of result, last field in the lowest bits
  typedef struct packed {
    logic [31:0] ring_write_pointer;
    logic [31:0] mem_read_address;
    logic [1:0]  mem_write_size;
    logic [31:0] mem_write_value;
    logic [31:0] mem_write_address;
    logic        mem_write_enable;
    logic [31:0] push_word;
    logic        dst_push;
    logic        src_pop;
  } tick_out_t;

endpackage

@@ hw/rtl/dmacr_step.sv @@
`timescale 1ns / 1ps

// Next-state and result logic for one channel tick
module dmacr_step import dmacr_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    st,
  input  tick_in_t  tick,
  output state_t    st_nxt,
  output tick_out_t res
);

  logic [7:0]  wc_dec;
  logic [7:0]  rc_dec;
  logic [7:0]  cc_dec;
  logic        write_now;
  logic        read_now;
  logic        hold;
  logic [31:0] rep_data;
  logic [31:0] cap_val;
  logic [31:0] mask;
  logic [31:0] entry;
  logic [1:0]  size_code;
  logic [31:0] ring_ofs;

  // Element size decode
  always_comb begin
    case (cfg.transfer_size)
      SZ_BYTE: begin
        entry    = 32'd1;
        rep_data = {4{tick.mem_data_in[7:0]}};
        cap_val  = {24'd0, st.capture_value[7:0]};
      end
      SZ_HALF: begin
        entry    = 32'd2;
        rep_data = {2{tick.mem_data_in[15:0]}};
        cap_val  = {16'd0, st.capture_value[15:0]};
      end
      default: begin
        entry    = 32'd4;
        rep_data = tick.mem_data_in;
        cap_val  = st.capture_value;
      end
    endcase
    size_code = (cfg.transfer_size > SZ_WORD) ? SZ_WORD : cfg.transfer_size;
  end

  assign mask     = ~(32'hFFFF_FFFF << cfg.ring_order);
  assign ring_ofs = (st.ring_pointer - cfg.ring_start) + entry;

  assign wc_dec = (st.write_countdown != 8'd0) ? st.write_countdown - 8'd1 : 8'd0;
  assign rc_dec = (st.read_countdown  != 8'd0) ? st.read_countdown  - 8'd1 : 8'd0;
  assign cc_dec = (st.capture_countdown != 8'd0) ? st.capture_countdown - 8'd1 : 8'd0;
  assign write_now = (st.write_countdown == 8'd1);
  assign read_now  = (st.read_countdown == 8'd1);

  always_comb begin
    st_nxt = st;
    res    = '0;
    hold   = 1'b0;
    if (cfg.channel_enabled) begin
      if (cfg.capture_mode) begin
        // Capture: commit on countdown expiry, then try a new pop
        st_nxt.capture_countdown = cc_dec;
        if (st.capture_countdown == 8'd1) begin
          res.mem_write_enable  = 1'b1;
          res.mem_write_address = st.ring_pointer;
          res.mem_write_value   = cap_val;
          res.mem_write_size    = size_code;
          st_nxt.ring_pointer   = cfg.ring_start + (ring_ofs & mask);
        end
        if (cc_dec == 8'd0 && tick.src_has_data) begin
          res.src_pop              = 1'b1;
          st_nxt.capture_value     = tick.src_word;
          st_nxt.capture_countdown = cfg.read_latency;
        end
      end else begin
        // Chain: push stage
        st_nxt.write_countdown = wc_dec;
        if (write_now) begin
          if (tick.dst_full) begin
            st_nxt.write_countdown = 8'd1;
          end else begin
            res.dst_push         = 1'b1;
            res.push_word        = st.pending_value;
            st_nxt.pending_value = 32'd0;
          end
        end
        // Chain: read stage, waits while a push is outstanding
        st_nxt.read_countdown = rc_dec;
        if (read_now) begin
          if (st_nxt.write_countdown != 8'd0) begin
            st_nxt.read_countdown = 8'd1;
            hold = 1'b1;
          end else begin
            st_nxt.pending_value   = rep_data;
            st_nxt.write_countdown = cfg.write_latency;
          end
        end
        // Chain: pop a new address
        if (!hold && st_nxt.read_countdown == 8'd0 && tick.src_has_data) begin
          res.src_pop            = 1'b1;
          st_nxt.pending_address = tick.src_word;
          st_nxt.read_countdown  = cfg.read_latency;
        end
      end
    end
    res.mem_read_address   = st_nxt.pending_address;
    res.ring_write_pointer = st_nxt.ring_pointer;
  end

endmodule

@@ hw/rtl/fifo_dma_channel_chain_and_ring.sv @@
`timescale 1ns / 1ps

// One DMA channel with address-chain read mode and ring-buffer capture.
// Each item on the in_ channel is one channel tick (source FIFO status and
// head word, destination full flag, memory read data); each tick gives
// exactly one item on the out_ channel (pop/push controls, capture write
// port and the current read address and ring pointer).
// An accepted item is held in the input register, evaluated combinationally
// and loaded into the result register, from which it is presented on out_.
// Throughput: one item per cycle while the receiver does not stall; the tick
// evaluation is the only step between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_tready drops only when both are occupied.
// Reset clears the channel state and loads the configuration reset values
// (disabled, chain mode, latencies 1, word size, ring base 0).
// The user writes configuration via cfg_we/cfg_index/cfg_wdata only while
// no item is in flight; the block does not enforce this. Writing the enable
// register restarts the channel; a ring base write reloads the ring pointer.
module fifo_dma_channel_chain_and_ring import dmacr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: src_has_data, src_word[32], dst_full, mem_data_in[32], zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: src_pop, dst_push, push_word[32], mem_write_enable,
  // mem_write_address[32], mem_write_value[32], mem_write_size[2],
  // mem_read_address[32], ring_write_pointer[32], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_wdata
);

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  state_t    st_clr;
  tick_in_t  in_r;
  logic      in_valid_r;
  tick_out_t res_nxt;
  tick_out_t out_r;
  logic      out_valid_r;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_r <= in_tdata[$bits(tick_in_t)-1:0];
    end
  end

  dmacr_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .tick   (in_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(tick_out_t)){1'b0}}, out_r};

  // Restart image: cleared state with the pointer at the ring start
  always_comb begin
    st_clr              = '0;
    st_clr.ring_pointer = cfg_r.ring_start;
  end

  // Configuration registers and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_enabled <= 1'b0;
      cfg_r.capture_mode    <= 1'b0;
      cfg_r.read_latency    <= 8'd1;
      cfg_r.write_latency   <= 8'd1;
      cfg_r.transfer_size   <= SZ_WORD;
      cfg_r.ring_start      <= 32'd0;
      cfg_r.ring_order      <= 5'd0;
      st_r                  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: begin
          cfg_r.channel_enabled <= cfg_wdata[0];
          st_r                  <= st_clr;
        end
        REG_CAPTURE:   cfg_r.capture_mode   <= cfg_wdata[0];
        REG_RD_LAT:    cfg_r.read_latency   <= cfg_wdata[7:0];
        REG_WR_LAT:    cfg_r.write_latency  <= cfg_wdata[7:0];
        REG_XFER_SIZE: cfg_r.transfer_size  <= cfg_wdata[1:0];
        REG_RING_BASE: begin
          cfg_r.ring_start  <= cfg_wdata;
          st_r.ring_pointer <= cfg_wdata;
        end
        REG_RING_LOG2: cfg_r.ring_order <= cfg_wdata[4:0];
        default: ;
      endcase
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // A tick never both pushes and commits a capture write
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_r.dst_push && out_r.mem_write_enable))
    else $error("push and capture commit in the same tick");

  // A disabled channel produces no pop, push or commit
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_r.channel_enabled && !cfg_we
      |=> !(out_r.src_pop || out_r.dst_push || out_r.mem_write_enable))
    else $error("disabled channel produced activity");

  // A chain-mode pop arms the read countdown with the read latency
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_we && cfg_r.channel_enabled && !cfg_r.capture_mode
      && res_nxt.src_pop
      |=> st_r.read_countdown == $past(cfg_r.read_latency)
        && st_r.pending_address == $past(in_r.src_word))
    else $error("chain pop did not arm read");

  // Reported read address follows the latched pending address
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_we |=> out_r.mem_read_address == st_r.pending_address)
    else $error("read address out of step with state");

endmodule

@@ verif/tb_fifo_dma_channel_chain_and_ring.sv @@
`timescale 1ns / 1ps

module tb_fifo_dma_channel_chain_and_ring import dmacr_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 14;
  localparam int PHASE_TICKS = 38;
  localparam int CALM_AFTER  = 480;
  localparam int SQUEEZE_PHASE = 5;

  // Codes with no name in the package
  localparam logic [1:0] SZ_ODD       = 2'd3;
  localparam logic       MODE_CHAIN   = 1'b0;
  localparam logic       MODE_CAPTURE = 1'b1;
  localparam logic [2:0] REG_UNUSED   = 3'd7;

  // Shadow of the channel: registers, tick state and results still to come
  class dma_tick_board;
    cfg_t      regs;
    state_t    st;
    tick_out_t due_ticks[$];
    int        faults;

    function new();
      regs = '0;
      regs.read_latency  = 8'd1;
      regs.write_latency = 8'd1;
      regs.transfer_size = SZ_WORD;
      faults = 0;
      restart();
    endfunction

    function void restart();
      st = '0;
      st.ring_pointer = regs.ring_start;
    endfunction

    function void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ENABLE: begin
          regs.channel_enabled = val[0];
          restart();
        end
        REG_CAPTURE:   regs.capture_mode = val[0];
        REG_RD_LAT:    regs.read_latency = val[7:0];
        REG_WR_LAT:    regs.write_latency = val[7:0];
        REG_XFER_SIZE: regs.transfer_size = val[1:0];
        REG_RING_BASE: begin
          regs.ring_start = val;
          st.ring_pointer = val;
        end
        REG_RING_LOG2: regs.ring_order = val[4:0];
        default: ;
      endcase
    endfunction

    // One channel tick
    function tick_out_t advance_channel(tick_in_t t);
      tick_out_t   r;
      logic [31:0] v;
      logic [31:0] ring_mask;
      logic [31:0] entry;
      logic        write_now;
      logic        read_now;
      logic        hold;
      r = '0;
      write_now = 1'b0;
      read_now = 1'b0;
      hold = 1'b0;
      if (regs.channel_enabled) begin
        if (regs.capture_mode) begin
          // capture commit, then pointer wraps inside the ring
          if (st.capture_countdown != 0) begin
            st.capture_countdown = st.capture_countdown - 8'd1;
            if (st.capture_countdown == 0) begin
              v = st.capture_value;
              if (regs.transfer_size == SZ_BYTE) v = v & 32'h0000_00FF;
              else if (regs.transfer_size == SZ_HALF) v = v & 32'h0000_FFFF;
              ring_mask = 32'((64'd1 << regs.ring_order) - 64'd1);
              entry = (regs.transfer_size == SZ_BYTE) ? 32'd1 :
                      (regs.transfer_size == SZ_HALF) ? 32'd2 : 32'd4;
              r.mem_write_enable  = 1'b1;
              r.mem_write_address = st.ring_pointer;
              r.mem_write_value   = v;
              r.mem_write_size    = (regs.transfer_size > SZ_WORD) ? SZ_WORD :
                                    regs.transfer_size;
              st.ring_pointer = regs.ring_start +
                  ((st.ring_pointer - regs.ring_start + entry) & ring_mask);
            end
          end
          if (st.capture_countdown == 0 && t.src_has_data) begin
            r.src_pop = 1'b1;
            st.capture_value = t.src_word;
            st.capture_countdown = regs.read_latency;
          end
        end else begin
          // push stage: retry while the destination is full
          if (st.write_countdown != 0) begin
            st.write_countdown = st.write_countdown - 8'd1;
            if (st.write_countdown == 0) write_now = 1'b1;
          end
          if (write_now) begin
            if (t.dst_full) begin
              st.write_countdown = 8'd1;
            end else begin
              r.dst_push = 1'b1;
              r.push_word = st.pending_value;
              st.pending_value = '0;
            end
          end
          // read stage: waits while a push is outstanding
          if (st.read_countdown != 0) begin
            st.read_countdown = st.read_countdown - 8'd1;
            if (st.read_countdown == 0) read_now = 1'b1;
          end
          if (read_now) begin
            if (st.write_countdown != 0) begin
              st.read_countdown = 8'd1;
              hold = 1'b1;
            end else begin
              if (regs.transfer_size == SZ_BYTE) v = {4{t.mem_data_in[7:0]}};
              else if (regs.transfer_size == SZ_HALF) v = {2{t.mem_data_in[15:0]}};
              else v = t.mem_data_in;
              st.pending_value = v;
              st.write_countdown = regs.write_latency;
            end
          end
          if (!hold && st.read_countdown == 0 && t.src_has_data) begin
            r.src_pop = 1'b1;
            st.pending_address = t.src_word;
            st.read_countdown = regs.read_latency;
          end
        end
      end
      r.mem_read_address   = st.pending_address;
      r.ring_write_pointer = st.ring_pointer;
      return r;
    endfunction

    function void note_tick(tick_in_t t);
      due_ticks.push_back(advance_channel(t));
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_tick(tick_out_t got);
      tick_out_t want;
      if (due_ticks.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result with none outstanding: %h", got);
        return;
      end
      want = due_ticks.pop_front();
      cmp_field("src_pop", 32'(want.src_pop), 32'(got.src_pop));
      cmp_field("dst_push", 32'(want.dst_push), 32'(got.dst_push));
      cmp_field("push_word", want.push_word, got.push_word);
      cmp_field("mem_write_enable", 32'(want.mem_write_enable),
                32'(got.mem_write_enable));
      cmp_field("mem_write_address", want.mem_write_address, got.mem_write_address);
      cmp_field("mem_write_value", want.mem_write_value, got.mem_write_value);
      cmp_field("mem_write_size", 32'(want.mem_write_size), 32'(got.mem_write_size));
      cmp_field("mem_read_address", want.mem_read_address, got.mem_read_address);
      cmp_field("ring_write_pointer", want.ring_write_pointer, got.ring_write_pointer);
    endfunction

    function void close_out();
      if (due_ticks.size() != 0) begin
        faults += due_ticks.size();
        $display("%0d results never arrived", due_ticks.size());
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [2:0]             cfg_index = '0;
  logic [31:0]            cfg_wdata = '0;

  dma_tick_board board;
  int  sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  squeeze = 1'b0;

  fifo_dma_channel_chain_and_ring u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_latency();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(1, 4));
  endfunction

  function automatic tick_in_t mk(logic has, logic [31:0] word, logic full,
                                  logic [31:0] mem);
    tick_in_t t;
    t.src_has_data = has;
    t.src_word     = word;
    t.dst_full     = full;
    t.mem_data_in  = mem;
    return t;
  endfunction

  function automatic tick_in_t rand_tick();
    return mk($urandom_range(0, 9) < 7, pick_word(), $urandom_range(0, 3) == 0,
              pick_word());
  endfunction

  // Offer one item, then maybe go quiet for a burst
  task automatic send_tick(input tick_in_t t);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - $bits(tick_in_t)){1'b0}}, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(t);
    sent++;
    if (sent >= CALM_AFTER) calm = 1'b1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Let every outstanding result drain before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.due_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_phase(input int p);
    logic [31:0] base;
    logic [31:0] lmask;
    case (p)
      // zero read latency, byte elements
      0: begin
        write_reg(REG_CAPTURE, 32'(MODE_CHAIN));
        write_reg(REG_RD_LAT, 32'd0);
        write_reg(REG_WR_LAT, 32'd1);
        write_reg(REG_XFER_SIZE, 32'(SZ_BYTE));
      end
      // zero write latency, halfword elements
      1: begin
        write_reg(REG_RD_LAT, 32'd2);
        write_reg(REG_WR_LAT, 32'd0);
        write_reg(REG_XFER_SIZE, 32'(SZ_HALF));
      end
      // ring smaller than one entry on a misaligned base, odd size code
      2: begin
        write_reg(REG_CAPTURE, 32'(MODE_CAPTURE));
        write_reg(REG_RD_LAT, 32'd1);
        write_reg(REG_XFER_SIZE, 32'(SZ_ODD));
        write_reg(REG_RING_LOG2, 32'd0);
        write_reg(REG_RING_BASE, 32'h0000_0013);
      end
      // largest ring, pointer runs over the top of the address space
      3: begin
        write_reg(REG_RD_LAT, 32'd3);
        write_reg(REG_XFER_SIZE, 32'(SZ_WORD));
        write_reg(REG_RING_LOG2, 32'd31);
        write_reg(REG_RING_BASE, 32'hFFFF_FFF9);
      end
      // longest latencies
      4: begin
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_CAPTURE, 32'(MODE_CHAIN));
        write_reg(REG_RD_LAT, 32'd255);
        write_reg(REG_WR_LAT, 32'd255);
      end
      // mode switch with the chain still busy
      5: begin
        write_reg(REG_CAPTURE, 32'(MODE_CAPTURE));
        write_reg(REG_RD_LAT, 32'd2);
        write_reg(REG_XFER_SIZE, 32'(SZ_HALF));
        write_reg(REG_RING_LOG2, 32'd3);
        write_reg(REG_RING_BASE, 32'h8000_0040);
      end
      6: begin
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_CAPTURE, 32'(MODE_CHAIN));
        write_reg(REG_RD_LAT, 32'd1);
        write_reg(REG_WR_LAT, 32'd4);
        write_reg(REG_XFER_SIZE, 32'(SZ_WORD));
      end
      default: begin
        if (!board.regs.channel_enabled || $urandom_range(0, 2) == 0)
          write_reg(REG_ENABLE, ($urandom_range(0, 7) == 0) ? 32'd0 : 32'd1);
        if ($urandom_range(0, 1))
          write_reg(REG_CAPTURE,
                    32'($urandom_range(0, 1) ? MODE_CAPTURE : MODE_CHAIN));
        if ($urandom_range(0, 1)) write_reg(REG_RD_LAT, 32'(pick_latency()));
        if ($urandom_range(0, 1)) write_reg(REG_WR_LAT, 32'(pick_latency()));
        if ($urandom_range(0, 1)) write_reg(REG_XFER_SIZE, $urandom_range(0, 3));
        if ($urandom_range(0, 1))
          write_reg(REG_RING_LOG2, ($urandom_range(0, 4) == 0) ?
                    $urandom_range(0, 31) : $urandom_range(2, 6));
        if ($urandom_range(0, 1)) begin
          lmask = 32'((64'd1 << board.regs.ring_order) - 64'd1);
          base = $urandom;
          if ($urandom_range(0, 3) != 0) base = base & ~lmask;
          write_reg(REG_RING_BASE, base);
        end
      end
    endcase
  endtask

  // Receiver: random back-pressure plus one long hold-off
  initial begin : result_sink
    int hold_left;
    bit pressed;
    hold_left = 0;
    pressed = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        board.check_tick(tick_out_t'(out_tdata[$bits(tick_out_t)-1:0]));
      if (squeeze && !pressed) begin
        pressed = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int p;
    int k;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // channel still disabled after reset: nothing moves
    send_tick(mk(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_tick(mk(1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000));

    // chain mode at reset latencies, word elements
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_ENABLE, 32'd1);
    send_tick(mk(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF));
    send_tick(mk(1'b1, 32'h8000_0001, 1'b1, 32'h1234_5678));
    send_tick(mk(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000));
    send_tick(mk(1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    send_tick(mk(1'b1, 32'hA5A5_A5A5, 1'b0, 32'h0000_FFFF));
    send_tick(mk(1'b0, 32'h0000_0000, 1'b0, 32'h8765_4321));
    send_tick(mk(1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000));

    // capture of bytes into a four-byte ring, wrapping once
    settle();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_CAPTURE, 32'(MODE_CAPTURE));
    write_reg(REG_XFER_SIZE, 32'(SZ_BYTE));
    write_reg(REG_RING_LOG2, 32'd2);
    write_reg(REG_RING_BASE, 32'h0000_0100);
    send_tick(mk(1'b1, 32'hFFFF_FF80, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    send_tick(mk(1'b1, 32'h1234_5678, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'h0000_00FF, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b1, 32'h0101_0101, 1'b0, 32'h0000_0000));
    send_tick(mk(1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000));

    // random phases under a spread of settings
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      configure_phase(p);
      for (k = 0; k < PHASE_TICKS; k++) begin
        if (p == SQUEEZE_PHASE && k == 5) squeeze = 1'b1;
        send_tick(rand_tick());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    board.close_out();
    if (board.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dmacr_pkg.sv
hw/rtl/dmacr_step.sv
hw/rtl/fifo_dma_channel_chain_and_ring.sv
verif/tb_fifo_dma_channel_chain_and_ring.sv
